// ----- hw/rtl/brf_pkg.sv -----
// Shared operation codes and the decoded-operation record for the byte ring FIFO.
package brf_pkg;
    localparam int DEPTH = 256;

    localparam logic [2:0] FUNC_PUSH    = 3'd0;
    localparam logic [2:0] FUNC_POP     = 3'd1;
    localparam logic [2:0] FUNC_ADVANCE = 3'd2;
    localparam logic [2:0] FUNC_DISCARD = 3'd3;
    localparam logic [2:0] FUNC_POKE    = 3'd4;
    localparam logic [2:0] FUNC_PEEK    = 3'd5;
    localparam logic [2:0] FUNC_PSEEK   = 3'd6;
    localparam logic [2:0] FUNC_BSEEK   = 3'd7;

    localparam int PATTERN_BYTES = 8;

    localparam logic [1:0] WHICH_NONE = 2'd0;
    localparam logic [1:0] WHICH_DATA = 2'd1;
    localparam logic [1:0] WHICH_ALT  = 2'd2;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  data_byte;
        logic [7:0]  alt_byte;
        logic [8:0]  count;
        logic [63:0] pattern;
        logic [3:0]  pattern_len;
    } t_op;
endpackage

// ----- hw/rtl/brf_front.sv -----
// Front end: accepts operations into a short command queue and clamps the pattern length.
module brf_front #(
    parameter int MAX_PATTERN = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    output logic         o_full,
    input  brf_pkg::t_op i_op,
    output logic         o_valid,
    input  logic         i_take,
    output brf_pkg::t_op o_op
);
    brf_pkg::t_op r_q [2];
    logic         r_wr;
    logic         r_rd;
    logic [1:0]   r_cnt;
    brf_pkg::t_op n_op;

    always_comb begin
        n_op = i_op;
        if (i_op.pattern_len > 4'(MAX_PATTERN)) begin
            n_op.pattern_len = 4'(MAX_PATTERN);
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_op    = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_q[r_wr] <= n_op;
        end
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) r_wr <= ~r_wr;
            if (i_take && o_valid) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(i_push && !o_full) - 2'(i_take && o_valid);
        end
    end
endmodule

// ----- hw/rtl/brf_back.sv -----
// Back end: byte store, pointers, seek walker and one-entry result register.
module brf_back (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_take,
    input  brf_pkg::t_op i_op,
    output logic         o_empty,
    input  logic         i_pop,
    output logic [7:0]   o_read_data,
    output logic [8:0]   o_moved,
    output logic [8:0]   o_found_at,
    output logic [1:0]   o_which_byte,
    output logic [8:0]   o_level
);
    localparam int AW = $clog2(brf_pkg::DEPTH);
    localparam int PW = AW + 1;
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;

    logic [7:0]    r_mem [brf_pkg::DEPTH];
    logic [7:0]    r_rdata;
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [2:0]    r_state;
    brf_pkg::t_op  r_op;
    logic [PW-1:0] r_idx;    // walk position, next byte to fetch
    logic [PW-1:0] r_start;  // current candidate start offset
    logic [3:0]    r_j;      // byte index inside candidate
    logic          r_out_v;
    logic [7:0]    r_rd_o;
    logic [8:0]    r_mv_o;
    logic [8:0]    r_fd_o;
    logic [1:0]    r_wb_o;

    logic [PW-1:0] w_fill;
    logic [PW-1:0] w_free;
    logic [PW-1:0] w_cnt;
    logic [PW-1:0] w_n;
    logic [7:0]    w_want;
    logic          w_start;
    logic [AW-1:0] w_raddr;
    logic          w_fetch;

    assign w_fill = r_wp - r_rp;
    assign w_free = PW'(brf_pkg::DEPTH) - w_fill;
    assign w_cnt  = (PW >= 9) ? PW'(i_op.count) : ((i_op.count > 9'(brf_pkg::DEPTH))
                    ? PW'(brf_pkg::DEPTH) : PW'(i_op.count));
    assign w_start = i_valid && (r_state == S_IDLE) && !r_out_v;
    assign o_take  = w_start;
    assign w_want  = r_op.pattern[{r_j[2:0], 3'b000} +: 8];

    always_comb begin
        w_fetch = 1'b0;
        w_raddr = r_rp[AW-1:0] + r_idx[AW-1:0];
        if (w_start && (i_op.func == brf_pkg::FUNC_POP || i_op.func == brf_pkg::FUNC_PEEK)) begin
            w_fetch = 1'b1;
            w_raddr = (i_op.func == brf_pkg::FUNC_PEEK) ? r_rp[AW-1:0] + AW'(i_op.count)
                                                       : r_rp[AW-1:0];
        end else if (r_state == S_WALK) begin
            w_fetch = 1'b1;
        end
    end

    always_comb begin
        w_n = (w_cnt < ((i_op.func == brf_pkg::FUNC_ADVANCE) ? w_free : w_fill))
            ? w_cnt : ((i_op.func == brf_pkg::FUNC_ADVANCE) ? w_free : w_fill);
    end

    always_ff @(posedge i_clk) begin
        if (w_fetch) r_rdata <= r_mem[w_raddr];
        if (w_start && i_op.func == brf_pkg::FUNC_PUSH && w_free != '0) begin
            r_mem[r_wp[AW-1:0]] <= i_op.data_byte;
        end
        if (w_start && i_op.func == brf_pkg::FUNC_POKE) begin
            r_mem[r_wp[AW-1:0] + AW'(i_op.count)] <= i_op.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_state <= S_IDLE;
            r_out_v <= 1'b0;
        end else begin
            if (r_out_v && i_pop) r_out_v <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_start) begin
                        r_op    <= i_op;
                        r_rd_o  <= '0;
                        r_mv_o  <= '0;
                        r_fd_o  <= '0;
                        r_wb_o  <= brf_pkg::WHICH_NONE;
                        r_idx   <= '0;
                        r_start <= '0;
                        r_j     <= '0;
                        r_state <= S_DONE;
                        case (i_op.func)
                            brf_pkg::FUNC_PUSH: begin
                                if (w_free != '0) begin
                                    r_wp   <= r_wp + 1'b1;
                                    r_mv_o <= 9'd1;
                                end
                            end
                            brf_pkg::FUNC_POP: begin
                                if (w_fill != '0) begin
                                    r_mv_o  <= 9'd1;
                                    if (w_fill == PW'(1)) begin
                                        r_wp <= '0;
                                        r_rp <= '0;
                                    end else begin
                                        r_rp <= r_rp + 1'b1;
                                    end
                                    r_state <= S_READ;
                                end
                            end
                            brf_pkg::FUNC_ADVANCE: begin
                                r_wp   <= r_wp + w_n;
                                r_mv_o <= 9'(w_n);
                            end
                            brf_pkg::FUNC_DISCARD: begin
                                r_mv_o <= 9'(w_n);
                                if (w_n == w_fill) begin
                                    r_wp <= '0;
                                    r_rp <= '0;
                                end else begin
                                    r_rp <= r_rp + w_n;
                                end
                            end
                            brf_pkg::FUNC_POKE: begin
                            end
                            brf_pkg::FUNC_PEEK: r_state <= S_READ;
                            brf_pkg::FUNC_PSEEK: begin
                                if (i_op.pattern_len != '0 &&
                                    w_fill >= PW'(i_op.pattern_len)) begin
                                    r_state <= S_WALK;
                                end
                            end
                            default: begin
                                if (w_fill != '0) r_state <= S_WALK;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_rd_o  <= r_rdata;
                    r_out_v <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_WALK: begin
                    // fetch byte r_idx this cycle; compare it next cycle
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_op.func == brf_pkg::FUNC_BSEEK) begin
                        if (r_rdata == r_op.data_byte) begin
                            r_wb_o  <= brf_pkg::WHICH_DATA;
                            r_state <= S_DONE;
                        end else if (r_rdata == r_op.alt_byte) begin
                            r_wb_o  <= brf_pkg::WHICH_ALT;
                            r_state <= S_DONE;
                        end else if (r_idx == w_fill) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_WALK;
                        end
                    end else begin
                        if (r_rdata == w_want) begin
                            if (r_j + 4'd1 == r_op.pattern_len) begin
                                r_fd_o  <= 9'(r_start) + 9'd1;
                                r_state <= S_DONE;
                            end else begin
                                r_j     <= r_j + 4'd1;
                                r_state <= S_WALK;
                            end
                        end else if (r_start + PW'(r_op.pattern_len) >= w_fill) begin
                            r_state <= S_DONE;
                        end else begin
                            // restart at next candidate
                            r_start <= r_start + 1'b1;
                            r_idx   <= r_start + 1'b1;
                            r_j     <= '0;
                            r_state <= S_WALK;
                        end
                    end
                end
                S_DONE: begin
                    r_out_v <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_empty      = !r_out_v;
    assign o_read_data  = r_rd_o;
    assign o_moved      = r_mv_o;
    assign o_found_at   = r_fd_o;
    assign o_which_byte = r_wb_o;
    assign o_level      = 9'(w_fill);
endmodule

// ----- hw/rtl/byte_ring_fifo_with_search_unit.sv -----
// Top level of the byte ring FIFO with search.
// Operations enter a two-entry command queue and run one at a time in the back end.
// Push, advance, discard and poke show their result through S_DONE after the back end
// takes them from the queue, pop of a stored byte and peek through S_READ; pop and peek
// read the store through its single registered port as they are taken. A pattern seek
// walks stored bytes in turns of S_WALK (fetch) and S_CMP (compare), restarting at the
// next candidate after each mismatch; a two-byte seek stops at the first byte that
// matches either byte or at the end of the fill. The result register holds one result
// and the back end takes the next operation only after it is popped.
module byte_ring_fifo_with_search_unit #(
    parameter int MAX_PATTERN = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_alt_byte,
    input  logic [8:0]  i_count,
    input  logic [63:0] i_pattern,
    input  logic [3:0]  i_pattern_len,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_read_data,
    output logic [8:0]  o_moved,
    output logic [8:0]  o_found_at,
    output logic [1:0]  o_which_byte,
    output logic [8:0]  o_level
);
    brf_pkg::t_op w_in;
    brf_pkg::t_op w_op;
    logic         w_valid;
    logic         w_take;

    assign w_in = '{func: i_func, data_byte: i_data_byte, alt_byte: i_alt_byte,
                    count: i_count, pattern: i_pattern, pattern_len: i_pattern_len};

    brf_front #(.MAX_PATTERN(MAX_PATTERN)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_op(w_in), .o_valid(w_valid), .i_take(w_take), .o_op(w_op)
    );

    brf_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_valid), .o_take(w_take),
        .i_op(w_op), .o_empty(empty), .i_pop(pop), .o_read_data(o_read_data),
        .o_moved(o_moved), .o_found_at(o_found_at), .o_which_byte(o_which_byte),
        .o_level(o_level)
    );
endmodule

// ----- hw/rtl/brf_checker.sv -----
// Port-level checker for the byte ring FIFO, bound to the top level.
module brf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [8:0] o_moved,
    input logic [8:0] o_found_at,
    input logic [1:0] o_which_byte,
    input logic [8:0] o_level
);
    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_level <= 9'd256) else $error("level out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_moved) && $stable(o_level)))
        else $error("result changed while waiting");
    a_which: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_which_byte != 2'd3) else $error("bad which_byte");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_found_at == '0 || o_which_byte == '0))
        else $error("two seek results at once");
endmodule

bind byte_ring_fifo_with_search_unit brf_checker u_brf_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .empty(empty), .pop(pop),
    .o_moved(o_moved), .o_found_at(o_found_at), .o_which_byte(o_which_byte),
    .o_level(o_level)
);
